[sv/per_entity_token_bucket_macros.svh]
// Assertion helpers for the token bucket block.
`ifndef PER_ENTITY_TOKEN_BUCKET_MACROS_SVH
`define PER_ENTITY_TOKEN_BUCKET_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define PETB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define PETB_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/petb_pkg.sv]
package petb_pkg;

  localparam int unsigned NumSlotsDef = 256;

  localparam int unsigned IdW    = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TokW   = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgW-1:0] CapReset    = 16'd100;
  localparam logic [CfgW-1:0] RefillReset = 16'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegCapacity = 1'b0,
    RegRefill   = 1'b1
  } cfg_reg_e;

  // one bucket slot as stored in the table
  typedef struct packed {
    logic             valid;
    logic [TokW-1:0]  tokens;
    logic [TimeW-1:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

[sv/petb_ram.sv]
module petb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/per_entity_token_bucket.sv]
// Per-entity token bucket: one request in, one verdict out.
// Stage 1 registers the request and its table read; the result register holds the update.
// Throughput: one request per cycle while the result is not stalled, set by the single
// table read-modify-write port pair; same-slot back-to-back requests are served by a
// write-forwarding register. Reset: asynchronous, active low; afterwards a clearing pass
// writes every slot of the table empty, with requests held off until it ends.
module per_entity_token_bucket #(
  parameter int unsigned NumSlots = petb_pkg::NumSlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [petb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [petb_pkg::CfgW-1:0]   cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [petb_pkg::IdW-1:0]    entity_id_i,
  input  logic [petb_pkg::TimeW-1:0]  time_now_i,
  input  logic [petb_pkg::TokW-1:0]   tokens_needed_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        verdict_o,
  output logic [petb_pkg::TokW-1:0]   remaining_o
);
  import petb_pkg::*;

  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumSlots - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] cap_q, refill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapReset;
      refill_q <= RefillReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegCapacity: cap_q    <= cfg_wdata_i;
        RegRefill:   refill_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Slot index: entity_id modulo the table depth
  // ---------------------------------------------------------------------------
  logic [SlotW-1:0] slot_in;

  if (NumSlots >= (1 << IdW)) begin : g_slot_direct
    assign slot_in = SlotW'(entity_id_i);
  end else begin : g_slot_mod
    // fixed lookup over every id value, built at elaboration
    localparam int unsigned NumIds = 1 << IdW;
    typedef logic [NumIds-1:0][SlotW-1:0] slot_tab_t;

    function automatic slot_tab_t slot_table();
      slot_tab_t tab;
      for (int i = 0; i < NumIds; i++) begin
        tab[i] = SlotW'(i % NumSlots);
      end
      return tab;
    endfunction

    localparam slot_tab_t SlotTab = slot_table();

    assign slot_in = SlotTab[entity_id_i];
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset: every slot written empty
  // ---------------------------------------------------------------------------
  logic             clr_busy_q;
  logic [SlotW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == LastSlot) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;

  // stage 1 moves into the result register when that is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Stage 1 request register
  // ---------------------------------------------------------------------------
  logic [SlotW-1:0] s1_slot_q;
  logic [TimeW-1:0] s1_time_q;
  logic [TokW-1:0]  s1_need_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_slot_q <= slot_in;
      s1_time_q <= time_now_i;
      s1_need_q <= tokens_needed_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot table
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  entry_t            new_entry;

  assign ram_we    = clr_busy_q || s1_adv;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : s1_slot_q;
  assign ram_wdata = clr_busy_q ? EntryW'(0) : new_entry;

  petb_ram #(
    .Width (EntryW),
    .Depth (NumSlots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (slot_in),
    .rdata_o (ram_rdata)
  );

  // Last update written, held for the request whose read met that write.
  logic             wr_valid_q;
  logic [SlotW-1:0] wr_slot_q;
  entry_t           wr_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else if (s1_adv) begin
      wr_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wr_slot_q  <= s1_slot_q;
      wr_entry_q <= new_entry;
    end
  end

  // ---------------------------------------------------------------------------
  // Bucket update
  // ---------------------------------------------------------------------------
  entry_t          cur;
  logic [TimeW-1:0] elapsed;
  logic [2*TokW-1:0] prod;
  logic            add_nz, add_over;
  logic [TokW:0]   add_sat, sum;
  logic [TokW-1:0] fill_tok, left_tok;
  logic [TimeW-1:0] fill_stamp;
  logic            allow;

  assign cur = (wr_valid_q && (wr_slot_q == s1_slot_q)) ? wr_entry_q : entry_t'(ram_rdata);

  // time running backwards counts as no time at all
  assign elapsed = (s1_time_q > cur.stamp) ? (s1_time_q - cur.stamp) : '0;

  // refill = elapsed * rate, saturated above 16 bits: anything that large clamps anyway
  assign prod     = elapsed[TokW-1:0] * refill_q;
  assign add_nz   = (elapsed != '0) && (refill_q != '0);
  assign add_over = (|elapsed[TimeW-1:TokW]) || (|prod[2*TokW-1:TokW]);
  assign add_sat  = add_over ? {1'b1, {TokW{1'b0}}} : {1'b0, prod[TokW-1:0]};
  assign sum      = {1'b0, cur.tokens} + add_sat;

  always_comb begin
    if (!cur.valid) begin
      // unused slot opens full
      fill_tok   = cap_q;
      fill_stamp = s1_time_q;
    end else if (add_nz) begin
      fill_tok   = (sum > {1'b0, cap_q}) ? cap_q : sum[TokW-1:0];
      fill_stamp = s1_time_q;
    end else begin
      // stamp stays when nothing was added
      fill_tok   = cur.tokens;
      fill_stamp = cur.stamp;
    end
  end

  assign allow    = fill_tok >= s1_need_q;
  assign left_tok = allow ? (fill_tok - s1_need_q) : fill_tok;

  assign new_entry.valid  = 1'b1;
  assign new_entry.tokens = left_tok;
  assign new_entry.stamp  = fill_stamp;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic            verdict_q;
  logic [TokW-1:0] remaining_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      verdict_q   <= !allow;
      remaining_q <= left_tok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign remaining_o = remaining_q;

endmodule

[sv/petb_checker.sv]
`include "per_entity_token_bucket_macros.svh"

module petb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      verdict_o,
  input logic [petb_pkg::TokW-1:0] remaining_o
);
  import petb_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      unique case ({in_acc, out_acc})
        2'b10:   pend_q <= pend_q + 2'd1;
        2'b01:   pend_q <= pend_q - 2'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  `PETB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) && $stable(remaining_o), "stalled result changed")
  `PETB_ASSERT(a_no_phantom, clk_i, rst_ni, out_valid_o |-> pend_q != 2'd0, "result without a request")
  `PETB_ASSERT(a_depth, clk_i, rst_ni, pend_q != 2'd3, "more than two requests in flight")
  `PETB_ASSERT_NR(a_clear_hold, clk_i, !rst_ni |=> !in_ready_o, "request taken during clearing")
  `PETB_ASSERT_NR(a_rst_out, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind per_entity_token_bucket petb_checker u_petb_checker (.*);
